// ===== design/lzfd_pkg.sv =====
// Package: shared types and constants of the LZ flag-byte image decoder.
`timescale 1ns / 1ps
`default_nettype none

package lzfd_pkg;

    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int DIM_W      = 10;
    localparam int POS_W      = 2 * DIM_W;
    localparam int OFF_W      = 12;
    localparam int LEN_W      = 6;
    localparam int FLAG_CNT_W = 4;

    localparam logic [LEN_W-1:0]      LEN_BIAS   = LEN_W'(3);
    localparam logic [FLAG_CNT_W-1:0] FLAGS_FULL = FLAG_CNT_W'(8);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    typedef enum logic [1:0] {
        PH_CTRL  = 2'd0,
        PH_ITEM  = 2'd1,
        PH_CMDHI = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_WRITE = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic issue_read;
        logic write_pixel;
    } dp_cmd_t;

    typedef struct packed {
        logic copy_start;
        logic copy_more;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/lzfd_ctrl.sv =====
// Controller: sequences input acceptance and the read/write steps of a copy.
`timescale 1ns / 1ps
`default_nettype none

module lzfd_ctrl
    import lzfd_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        cmd.accept      = 1'b0;
        cmd.issue_read  = 1'b0;
        cmd.write_pixel = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = status.out_free;
                cmd.accept = s_tvalid && status.out_free;
                if (cmd.accept && status.copy_start) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (status.out_free) begin
                    cmd.issue_read = 1'b1;
                    state_next     = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write_pixel = 1'b1;
                state_next      = status.copy_more ? ST_READ : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a history read is always followed by its write step
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue_read |=> cmd.write_pixel)
        else $error("read step not followed by write step");

    // no item is taken while a copy is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.write_pixel && status.copy_more) |=> !s_tready)
        else $error("input taken during copy");

endmodule

`default_nettype wire

// ===== design/lzfd_dp.sv =====
// Datapath: parse registers, pixel position, history memory and output register.
`timescale 1ns / 1ps
`default_nettype none

module lzfd_dp
    import lzfd_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  wire  [7:0]        s_tdata,
    input  wire  [0:0]        s_tuser,
    input  wire               m_tready,
    output logic              m_tvalid,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic [1:0]        m_tuser,
    input  wire  [DIM_W-1:0]  cfg_width,
    input  wire  [DIM_W-1:0]  cfg_height,
    input  wire               cfg_mode
);

    logic [7:0] hist_mem [HIST_DEPTH];
    logic [7:0] rd_data_reg;

    phase_t                phase_reg, phase_next;
    logic [FLAG_CNT_W-1:0] flags_reg, flags_next;
    logic [7:0]            shift_reg, shift_next;
    logic [7:0]            lo_reg, lo_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  fin_reg, fin_next;
    logic [POS_W-1:0]      total;
    logic [LEN_W-1:0]      copy_left_reg, copy_left_next;
    logic [OFF_W-1:0]      off_reg, off_next;
    logic                  bad_reg, bad_next;

    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_pix_reg, out_pix_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_done_reg, out_done_next;
    logic                  out_bad_reg, out_bad_next;
    logic                  load_out;

    logic                  sof;
    logic [POS_W-1:0]      pos_e;
    phase_t                phase_e;
    logic [FLAG_CNT_W-1:0] flags_e, flags_adv;
    logic [7:0]            shift_e;
    logic                  fin_e;
    logic                  active;
    logic                  lit_done;
    logic                  copy_done;
    logic [15:0]           cmd_word;
    logic [7:0]            copy_pix;

    logic                  mem_we;
    logic [HIST_AW-1:0]    mem_waddr;
    logic [7:0]            mem_wdata;

    assign total     = POS_W'(cfg_width) * POS_W'(cfg_height);
    assign sof       = s_tuser[0];
    assign pos_e     = sof ? '0 : pos_reg;
    assign phase_e   = sof ? PH_CTRL : phase_reg;
    assign flags_e   = sof ? '0 : flags_reg;
    assign shift_e   = sof ? '0 : shift_reg;
    assign fin_e     = sof ? 1'b0 : fin_reg;
    assign active    = !fin_e && (pos_e < total);
    assign lit_done  = (POS_W'(pos_e + POS_W'(1)) == total);
    assign copy_done = (POS_W'(pos_reg + POS_W'(1)) == total);
    assign flags_adv = (flags_e != '0) ? FLAG_CNT_W'(flags_e - FLAG_CNT_W'(1)) : '0;
    assign cmd_word  = {s_tdata, lo_reg};
    assign copy_pix  = bad_reg ? 8'd0 : rd_data_reg;

    assign status.copy_start = active && (phase_e == PH_CMDHI);
    assign status.copy_more  = (copy_left_reg != LEN_W'(1)) && !copy_done;
    assign status.out_free   = !out_valid_reg || m_tready;

    always_comb begin
        phase_next     = phase_reg;
        flags_next     = flags_reg;
        shift_next     = shift_reg;
        lo_next        = lo_reg;
        pos_next       = pos_reg;
        fin_next       = fin_reg;
        copy_left_next = copy_left_reg;
        off_next       = off_reg;
        bad_next       = bad_reg;
        load_out       = 1'b0;
        out_pix_next   = out_pix_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_bad_next   = out_bad_reg;
        mem_we         = 1'b0;
        mem_waddr      = HIST_AW'(pos_e);
        mem_wdata      = s_tdata;

        if (cmd.accept) begin
            pos_next   = pos_e;
            phase_next = phase_e;
            flags_next = flags_e;
            shift_next = shift_e;
            fin_next   = fin_e;
            if (active) begin
                unique case (phase_e)
                    PH_ITEM: begin
                        if (shift_e[0]) begin
                            mem_we        = 1'b1;
                            load_out      = 1'b1;
                            out_pix_next  = s_tdata;
                            out_last_next = 1'b1;
                            out_done_next = lit_done;
                            out_bad_next  = 1'b0;
                            pos_next      = POS_W'(pos_e + POS_W'(1));
                            shift_next    = shift_e >> 1;
                            flags_next    = flags_adv;
                            phase_next    = (flags_adv == '0) ? PH_CTRL : PH_ITEM;
                            if (lit_done) begin
                                fin_next   = 1'b1;
                                phase_next = PH_CTRL;
                            end
                        end else begin
                            lo_next    = s_tdata;
                            phase_next = PH_CMDHI;
                        end
                    end
                    PH_CMDHI: begin
                        if (cfg_mode) begin
                            copy_left_next = LEN_W'(cmd_word[3:0]) + LEN_BIAS;
                            off_next       = cmd_word[15:4];
                        end else begin
                            copy_left_next = LEN_W'(cmd_word[4:0]) + LEN_BIAS;
                            off_next       = OFF_W'(cmd_word[15:5]);
                        end
                        shift_next = shift_e >> 1;
                        flags_next = flags_adv;
                        phase_next = (flags_adv == '0) ? PH_CTRL : PH_ITEM;
                    end
                    default: begin
                        shift_next = s_tdata;
                        flags_next = FLAGS_FULL;
                        phase_next = PH_ITEM;
                    end
                endcase
            end
        end

        if (cmd.issue_read) begin
            bad_next = (off_reg == '0) || (POS_W'(off_reg) > pos_reg);
        end

        if (cmd.write_pixel) begin
            mem_we         = 1'b1;
            mem_waddr      = HIST_AW'(pos_reg);
            mem_wdata      = copy_pix;
            load_out       = 1'b1;
            out_pix_next   = copy_pix;
            out_last_next  = (copy_left_reg == LEN_W'(1)) || copy_done;
            out_done_next  = copy_done;
            out_bad_next   = bad_reg;
            pos_next       = POS_W'(pos_reg + POS_W'(1));
            copy_left_next = LEN_W'(copy_left_reg - LEN_W'(1));
            if (copy_done) begin
                fin_next   = 1'b1;
                phase_next = PH_CTRL;
            end
        end

        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_CTRL;
            flags_reg     <= '0;
            shift_reg     <= '0;
            lo_reg        <= '0;
            pos_reg       <= '0;
            fin_reg       <= 1'b0;
            copy_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            flags_reg     <= flags_next;
            shift_reg     <= shift_next;
            lo_reg        <= lo_next;
            pos_reg       <= pos_next;
            fin_reg       <= fin_next;
            copy_left_reg <= copy_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg      <= off_next;
        bad_reg      <= bad_next;
        out_pix_reg  <= out_pix_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
        out_bad_reg  <= out_bad_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue_read) begin
            rd_data_reg <= hist_mem[HIST_AW'(pos_reg - POS_W'(off_reg))];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_bad_reg, out_done_reg};

    // a waiting result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten");

    // a copy step only runs with pixels left to copy
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_pixel |-> (copy_left_reg != '0))
        else $error("copy step with empty count");

endmodule

`default_nettype wire

// ===== design/lz_flag_byte_image_decoder_top.sv =====
// LZ flag-byte image decoder: configuration registers and controller/datapath.
//
// Input stream s_*: one compressed byte per item in s_tdata, s_tuser[0] marks the
// start of an image (position cleared, byte read as a control byte).
// Output stream m_*: one decoded pixel per item; m_tlast marks the last pixel
// caused by an input item, m_tuser[0] the pixel completing the image and
// m_tuser[1] a copy with a bad back reference (pixel forced to zero).
// APB port: width at 0x0, height at 0x4, offset mode at 0x8; pready tied high.
// A literal is in the output register in the cycle after acceptance. After the high
// byte of a copy the input is refused until its last pixel is written: each pixel
// is a registered history read followed by a write-back and output load, so back
// references of any distance, overlap included, see every earlier pixel. A stalled
// receiver holds the output register, and the input is refused until the register
// can be reloaded.
// Reset returns the parser to expect a control byte at pixel zero, sets the
// image size to zero and offset mode to one; the history needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module lz_flag_byte_image_decoder_top
    import lzfd_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // in_byte
    input  wire  [0:0]  s_tuser,   // start_of_image
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // pixel_value
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // image_done, bad_reference
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             mode_reg;
    logic             cfg_wr;
    dp_cmd_t          cmd;
    dp_status_t       status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            height_reg <= '0;
            mode_reg   <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr[3:2] == REG_WIDTH) begin
                width_reg <= pwdata[DIM_W-1:0];
            end
            if (paddr[3:2] == REG_HEIGHT) begin
                height_reg <= pwdata[DIM_W-1:0];
            end
            if (paddr[3:2] == REG_MODE) begin
                mode_reg <= pwdata[0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[3:2] == REG_WIDTH) begin
            prdata = 32'(width_reg);
        end else if (paddr[3:2] == REG_HEIGHT) begin
            prdata = 32'(height_reg);
        end else if (paddr[3:2] == REG_MODE) begin
            prdata = 32'(mode_reg);
        end
    end

    lzfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lzfd_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .cfg_mode   (mode_reg)
    );

endmodule

`default_nettype wire

// ===== tb/lzfd_pixel_checker.sv =====
// Checker for the LZ flag-byte image decoder: predicts decoded pixels and compares them.
`timescale 1ns / 1ps

module lzfd_pixel_checker
    import lzfd_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [7:0]  s_tdata,   // in_byte
    input  wire  [0:0]  s_tuser,   // start_of_image
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [7:0]  m_tdata,   // pixel_value
    input  wire         m_tlast,
    input  wire  [1:0]  m_tuser,   // image_done, bad_reference
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire         pready,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output int          fail_count,
    output int          pixels_owed
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       done;
        logic       bad;
    } pixel_t;

    pixel_t pixels_due[$];
    pixel_t head_px;
    int     pixels_seen;

    logic [DIM_W-1:0]      width_r;
    logic [DIM_W-1:0]      height_r;
    logic                  mode_r;
    phase_t                phase_r;
    logic [FLAG_CNT_W-1:0] flags_r;
    logic [7:0]            flag_bits_r;
    logic [7:0]            cmd_lo_r;
    logic [POS_W-1:0]      pos_r;
    logic                  done_r;
    logic [7:0]            history [HIST_DEPTH];

    initial begin
        fail_count  = 0;
        pixels_seen = 0;
        pixels_owed = 0;
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic clear_parser();
        phase_r     = PH_CTRL;
        flags_r     = '0;
        flag_bits_r = '0;
        pos_r       = '0;
        done_r      = 1'b0;
    endtask

    task automatic advance_flag();
        flag_bits_r = flag_bits_r >> 1;
        if (flags_r != 0) flags_r = flags_r - 1'b1;
        if (flags_r == 0) phase_r = PH_CTRL;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic sof);
        logic [POS_W-1:0] total;
        logic [15:0]      cmd;
        int unsigned      len;
        int unsigned      off;
        int unsigned      i;
        pixel_t           px;
        if (sof) clear_parser();
        total = POS_W'(width_r) * POS_W'(height_r);
        if (done_r || pos_r >= total) return;
        if (phase_r == PH_ITEM && flag_bits_r[0]) begin
            px.value = b;
            px.last  = 1'b1;
            px.done  = (pos_r + 1 == total);
            px.bad   = 1'b0;
            history[pos_r[HIST_AW-1:0]] = b;
            pixels_due.push_back(px);
            pos_r = pos_r + 1'b1;
            advance_flag();
            if (px.done) begin
                done_r  = 1'b1;
                phase_r = PH_CTRL;
            end
        end else if (phase_r == PH_ITEM) begin
            cmd_lo_r = b;
            phase_r  = PH_CMDHI;
        end else if (phase_r == PH_CMDHI) begin
            cmd = {b, cmd_lo_r};
            if (mode_r) begin
                len = cmd[3:0];
                off = cmd[15:4];
            end else begin
                len = cmd[4:0];
                off = cmd[15:5];
            end
            len = len + LEN_BIAS;
            phase_r = PH_ITEM;
            advance_flag();
            for (i = 0; i < len && pos_r < total; i++) begin
                px.bad   = (off == 0) || (off > pos_r);
                px.value = px.bad ? 8'h00 : history[HIST_AW'(pos_r - off)];
                px.done  = (pos_r + 1 == total);
                px.last  = px.done || (i == len - 1);
                history[pos_r[HIST_AW-1:0]] = px.value;
                pixels_due.push_back(px);
                pos_r = pos_r + 1'b1;
                if (px.done) begin
                    done_r  = 1'b1;
                    phase_r = PH_CTRL;
                end
            end
        end else begin
            flag_bits_r = b;
            flags_r     = FLAGS_FULL;
            phase_r     = PH_ITEM;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_r  = '0;
            height_r = '0;
            mode_r   = 1'b1;
            cmd_lo_r = '0;
            clear_parser();
            pixels_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WIDTH:  width_r  = pwdata[DIM_W-1:0];
                    REG_HEIGHT: height_r = pwdata[DIM_W-1:0];
                    REG_MODE:   mode_r   = pwdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready) begin
                if (pixels_due.size() == 0) begin
                    report($sformatf("pixel %0d (%02h) with none expected",
                                     pixels_seen, m_tdata));
                end else begin
                    head_px = pixels_due.pop_front();
                    if (m_tdata !== head_px.value)
                        report($sformatf("pixel %0d value %02h, expected %02h",
                                         pixels_seen, m_tdata, head_px.value));
                    if (m_tlast !== head_px.last)
                        report($sformatf("pixel %0d tlast %b, expected %b",
                                         pixels_seen, m_tlast, head_px.last));
                    if (m_tuser[0] !== head_px.done)
                        report($sformatf("pixel %0d image_done %b, expected %b",
                                         pixels_seen, m_tuser[0], head_px.done));
                    if (m_tuser[1] !== head_px.bad)
                        report($sformatf("pixel %0d bad_reference %b, expected %b",
                                         pixels_seen, m_tuser[1], head_px.bad));
                end
                pixels_seen++;
            end
        end
        pixels_owed = pixels_due.size();
    end

endmodule

// ===== tb/lz_flag_byte_image_decoder_top_tb.sv =====
// Testbench top for the LZ flag-byte image decoder: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module lz_flag_byte_image_decoder_top_tb;
    import lzfd_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN       = 24;
    localparam int HOLD_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    wire         s_tready;
    logic [7:0]  s_tdata;   // in_byte
    logic [0:0]  s_tuser;   // start_of_image
    wire         m_tvalid;
    logic        m_tready;
    wire  [7:0]  m_tdata;   // pixel_value
    wire         m_tlast;
    wire  [1:0]  m_tuser;   // image_done, bad_reference
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    int   fail_count;
    int   pixels_owed;
    int   stall_cycles;
    int   stream_items;
    int   gen_width;
    int   gen_height;
    logic gen_mode;
    bit   hold_go;
    bit   hold_done;
    bit   no_gaps;

    lz_flag_byte_image_decoder_top u_top (.*);

    lzfd_pixel_checker u_checker (.*);

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic sof);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        do @(posedge aclk); while (!s_tready);
        stream_items++;
        @(negedge aclk);
    endtask

    // copy command, little-endian, packed for the current offset mode
    task automatic send_copy(input int off, input int len);
        logic [15:0] o;
        logic [15:0] l;
        logic [15:0] cmd;
        o = off;
        l = len;
        cmd = gen_mode ? {o[11:0], l[3:0]} : {o[10:0], l[4:0]};
        send_byte(cmd[7:0], 1'b0);
        send_byte(cmd[15:8], 1'b0);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pixels_owed != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic configure(input int w, input int h, input logic mode);
        settle();
        apb_write({REG_WIDTH, 2'b00}, 32'(w));
        apb_write({REG_HEIGHT, 2'b00}, 32'(h));
        apb_write({REG_MODE, 2'b00}, 32'(mode));
        gen_width  = w;
        gen_height = h;
        gen_mode   = mode;
    endtask

    // mostly well-formed image streams, with stray bytes and restarts mixed in
    task automatic gen_image(input int budget);
        int         gpos;
        int         gtotal;
        int         sent;
        int         fi;
        int         len;
        int         off;
        int         r;
        int         maxoff;
        int         maxlen;
        logic [7:0] ctrl;
        gtotal = gen_width * gen_height;
        maxoff = gen_mode ? 4095 : 2047;
        maxlen = gen_mode ? 15 : 31;
        gpos   = 0;
        sent   = 0;
        ctrl   = $urandom_range(0, 255);
        send_byte(ctrl, 1'b1);
        if (gtotal > 0) sent++;
        while (gpos < gtotal && sent < budget) begin
            for (fi = 0; fi < 8 && gpos < gtotal && sent < budget; fi++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_byte($urandom_range(0, 255), 1'b0);
                    sent++;
                end
                if (ctrl[fi]) begin
                    send_byte($urandom_range(0, 255), 1'b0);
                    gpos++;
                    sent++;
                end else begin
                    len = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3)
                                                     : $urandom_range(0, maxlen);
                    r = $urandom_range(0, 99);
                    if (gpos > 0 && r < 85)
                        off = $urandom_range(1, (gpos < maxoff) ? gpos : maxoff);
                    else if (r < 92)
                        off = 0;
                    else
                        off = $urandom_range(0, maxoff);
                    send_copy(off, len);
                    gpos += len + 3;
                    sent += 2;
                end
            end
            if (gpos < gtotal && sent < budget) begin
                ctrl = $urandom_range(0, 255);
                if ($urandom_range(0, 29) == 0) begin
                    send_byte(ctrl, 1'b1);
                    gpos = 0;
                end else begin
                    send_byte(ctrl, 1'b0);
                end
                sent++;
            end
        end
        if (gpos >= gtotal && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) send_byte($urandom_range(0, 255), 1'b0);
    endtask

    initial begin : rx_side
        int rx_gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_go && !hold_done) begin
                // long hold-off so the decoder backs up into its input
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 20))
                    @(negedge aclk);
                rx_gap = pick_gap();
                if (rx_gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (rx_gap) @(negedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : tx_side
        int w;
        int h;
        int r;
        int phase_no;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        stall_cycles = 0;
        stream_items = 0;
        hold_go      = 1'b0;
        hold_done    = 1'b0;
        no_gaps      = 1'b0;
        gen_width    = 0;
        gen_height   = 0;
        gen_mode     = 1'b1;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 32-pixel image: literals at both extremes, zero offset, overlapping
        // repeat, reference before the start, and a copy cut short at the end
        configure(8, 4, 1'b1);
        send_byte(8'h05, 1'b1);
        send_byte(8'hff, 1'b0);
        send_copy(0, 0);
        send_byte(8'h00, 1'b0);
        send_copy(1, 15);
        send_copy(100, 2);
        send_copy(4095, 15);
        send_byte(8'haa, 1'b0);
        send_byte(8'h55, 1'b0);

        // long-length mode, widest image, restart in mid-image
        configure(1023, 1, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b0);
        send_copy(1, 31);
        send_copy(2047, 31);
        send_byte(8'hfe, 1'b1);
        send_copy(1, 1);

        // size shrunk below the position, then an empty image
        configure(2, 1, 1'b0);
        send_byte(8'h33, 1'b0);
        configure(0, 0, 1'b1);
        send_byte(8'hc3, 1'b1);

        hold_go  = 1'b1;
        phase_no = 0;
        while (stream_items < 95) begin
            r = (phase_no == 0) ? 1 : $urandom_range(0, 9);
            case (r)
                0: begin w = 1023; h = 1; end
                1: begin w = 1; h = 1023; end
                2: begin w = 0; h = $urandom_range(0, 1023); end
                3: begin w = $urandom_range(1, 1023); h = 0; end
                default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 8); end
            endcase
            configure(w, h, $urandom_range(0, 1));
            no_gaps = ($urandom_range(0, 4) == 0);
            gen_image($urandom_range(8, 30));
            phase_no++;
        end

        settle();
        repeat (40) @(negedge aclk);
        if (fail_count == 0 && pixels_owed == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== lz_flag_byte_image_decoder_top.f =====
design/lzfd_pkg.sv
design/lzfd_ctrl.sv
design/lzfd_dp.sv
design/lz_flag_byte_image_decoder_top.sv
tb/lzfd_pixel_checker.sv
tb/lz_flag_byte_image_decoder_top_tb.sv
